@@ rtl/core/csf_pkg.sv @@
// Shared types and constants for the curve subdivision filter.
// No dependencies; every other file in rtl/core uses this package.
package csf_pkg;

    // coordinate width and sum headroom (taps sum to 128, i.e. 7 bits, plus sign slack)
    localparam int COORD_BITS = 16;
    localparam int TAP_SHIFT  = 7;
    localparam int TAP_SCALE  = 1 << TAP_SHIFT;
    localparam int SUM_BITS   = COORD_BITS + TAP_SHIFT + 1;

    // four held points plus the incoming one
    localparam int WIN_DEPTH  = 4;
    localparam int TAP_COUNT  = WIN_DEPTH + 1;
    localparam int FILL_BITS  = $clog2(WIN_DEPTH + 1);

    // five-tap kernel 1,28,70,28,1 and four-tap kernel 8,56,56,8
    localparam int TAP5_EDGE  = 1;
    localparam int TAP5_NEAR  = 28;
    localparam int TAP5_MID   = 70;
    localparam int TAP4_OUTER = 8;
    localparam int TAP4_INNER = 56;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic [FILL_BITS-1:0]         fill_t;

    // samples ordered oldest to newest, last one is the incoming point
    typedef coord_t tap_vec_t [TAP_COUNT];

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   start_of_curve;
    } point_beat_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   pair_last;
    } refined_beat_t;

endpackage

@@ rtl/core/csf_taps.sv @@
// One coordinate of the refinement kernel: weighted sum and divide by 128.
// Depends on csf_pkg.
module csf_taps (
    input  csf_pkg::tap_vec_t samples,
    input  logic              pair_last,
    output csf_pkg::coord_t   result
);

    localparam csf_pkg::sum_t W5_EDGE  = csf_pkg::sum_t'(csf_pkg::TAP5_EDGE);
    localparam csf_pkg::sum_t W5_NEAR  = csf_pkg::sum_t'(csf_pkg::TAP5_NEAR);
    localparam csf_pkg::sum_t W5_MID   = csf_pkg::sum_t'(csf_pkg::TAP5_MID);
    localparam csf_pkg::sum_t W4_OUTER = csf_pkg::sum_t'(csf_pkg::TAP4_OUTER);
    localparam csf_pkg::sum_t W4_INNER = csf_pkg::sum_t'(csf_pkg::TAP4_INNER);
    localparam csf_pkg::sum_t ROUND_UP = csf_pkg::sum_t'(csf_pkg::TAP_SCALE - 1);

    csf_pkg::sum_t ext [csf_pkg::TAP_COUNT];
    csf_pkg::sum_t sum5;
    csf_pkg::sum_t sum4;
    csf_pkg::sum_t sum_sel;
    csf_pkg::sum_t biased;
    csf_pkg::sum_t quot;

    // sign extend samples to sum width
    always_comb
    begin
        for (int i = 0; i < csf_pkg::TAP_COUNT; i++)
        begin
            ext[i] = csf_pkg::sum_t'(samples[i]);
        end
    end

    // both kernels, constant weights reduce to shift-and-add
    assign sum5 = W5_EDGE * ext[0] + W5_NEAR * ext[1] + W5_MID * ext[2]
                + W5_NEAR * ext[3] + W5_EDGE * ext[4];
    assign sum4 = W4_OUTER * ext[1] + W4_INNER * ext[2]
                + W4_INNER * ext[3] + W4_OUTER * ext[4];

    assign sum_sel = pair_last ? sum4 : sum5;

    // divide by 128 truncating toward zero: bias negatives before the shift
    assign biased = sum_sel[csf_pkg::SUM_BITS-1] ? sum_sel + ROUND_UP : sum_sel;
    assign quot   = biased >>> csf_pkg::TAP_SHIFT;
    assign result = quot[csf_pkg::COORD_BITS-1:0];

endmodule

@@ rtl/core/curve_subdivision_filter.sv @@
// Streaming degree-7 B-spline subdivision of a 2-D polyline, top level.
// Depends on csf_pkg and csf_taps.
//
// Points enter on the point channel; start_of_curve empties the window so the
// point begins a new curve. The first four points of a curve only fill the
// window. Every later point yields two beats on the refined channel, the
// five-tap point (pair_last 0) then the four-tap point (pair_last 1), and the
// next point is taken no sooner than the second beat moves into the single
// refined output register. A point is held in one stage register together with
// its window, and the kernel between that stage and the output register picks
// the tap set by the pair phase; a result passes the stage, then the output.
module curve_subdivision_filter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   point_valid,
    output logic                   point_ready,
    input  csf_pkg::point_beat_t   point,
    output logic                   refined_valid,
    input  logic                   refined_ready,
    output csf_pkg::refined_beat_t refined
);

    // window of last four points, index 0 oldest
    csf_pkg::coord_t window_x_reg [csf_pkg::WIN_DEPTH];
    csf_pkg::coord_t window_y_reg [csf_pkg::WIN_DEPTH];
    csf_pkg::fill_t  fill_count_reg, fill_count_next;

    // stage holding a point that produces a pair
    logic              stage_valid_reg, stage_valid_next;
    logic              stage_phase_reg, stage_phase_next;
    csf_pkg::tap_vec_t stage_x_reg;
    csf_pkg::tap_vec_t stage_y_reg;

    // result register
    logic                   out_valid_reg, out_valid_next;
    csf_pkg::refined_beat_t out_data_reg;

    csf_pkg::fill_t  fill_eff;
    logic            accept;
    logic            produce;
    logic            load;
    csf_pkg::coord_t tap_x;
    csf_pkg::coord_t tap_y;

    // handshake and control
    assign load        = stage_valid_reg && (!out_valid_reg || refined_ready);
    assign point_ready = !stage_valid_reg || (load && stage_phase_reg);
    assign accept      = point_valid && point_ready;
    assign fill_eff    = point.start_of_curve ? '0 : fill_count_reg;
    assign produce     = (fill_eff == csf_pkg::fill_t'(csf_pkg::WIN_DEPTH));

    always_comb
    begin
        fill_count_next  = fill_count_reg;
        stage_valid_next = stage_valid_reg;
        stage_phase_next = stage_phase_reg;
        out_valid_next   = out_valid_reg;

        // output register drains or refills
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (refined_ready)
        begin
            out_valid_next = 1'b0;
        end

        // pair phase advance, stage frees after the second beat
        if (load)
        begin
            if (stage_phase_reg)
            begin
                stage_valid_next = 1'b0;
                stage_phase_next = 1'b0;
            end
            else
            begin
                stage_phase_next = 1'b1;
            end
        end

        // new point: count up to a full window, capture if it yields a pair
        if (accept)
        begin
            if (produce)
            begin
                fill_count_next  = fill_eff;
                stage_valid_next = 1'b1;
                stage_phase_next = 1'b0;
            end
            else
            begin
                fill_count_next = fill_eff + csf_pkg::fill_t'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg  <= '0;
            stage_valid_reg <= 1'b0;
            stage_phase_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_count_reg  <= fill_count_next;
            stage_valid_reg <= stage_valid_next;
            stage_phase_reg <= stage_phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // window shift and stage capture; entries past the fill count are never read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < csf_pkg::WIN_DEPTH - 1; i++)
            begin
                window_x_reg[i] <= window_x_reg[i+1];
                window_y_reg[i] <= window_y_reg[i+1];
            end
            window_x_reg[csf_pkg::WIN_DEPTH-1] <= point.point_x;
            window_y_reg[csf_pkg::WIN_DEPTH-1] <= point.point_y;

            if (produce)
            begin
                for (int i = 0; i < csf_pkg::WIN_DEPTH; i++)
                begin
                    stage_x_reg[i] <= window_x_reg[i];
                    stage_y_reg[i] <= window_y_reg[i];
                end
                stage_x_reg[csf_pkg::WIN_DEPTH] <= point.point_x;
                stage_y_reg[csf_pkg::WIN_DEPTH] <= point.point_y;
            end
        end
    end

    // kernel for each coordinate
    csf_taps u_taps_x (
        .samples   (stage_x_reg),
        .pair_last (stage_phase_reg),
        .result    (tap_x)
    );

    csf_taps u_taps_y (
        .samples   (stage_y_reg),
        .pair_last (stage_phase_reg),
        .result    (tap_y)
    );

    // result beat capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.out_x     <= tap_x;
            out_data_reg.out_y     <= tap_y;
            out_data_reg.pair_last <= stage_phase_reg;
        end
    end

    assign refined_valid = out_valid_reg;
    assign refined       = out_data_reg;

endmodule
